/* sv/ipv6p_pkg.sv */
// ----------------------------------------------------------------------------
// IPv6 text parser package
// Character codes, the hex digit decoder and the snapshot type that carries
// one finished text from the character unit to the assembly stage.
// ----------------------------------------------------------------------------
package ipv6p_pkg;

	localparam int GROUP_SLOTS = 8;
	localparam int GROUP_IDX_W = $clog2(GROUP_SLOTS);
	localparam int GROUP_CNT_W = GROUP_IDX_W + 1;
	localparam int GROUP_W     = 16;

	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;

	localparam logic [7:0] PREFIX_MAX = 8'd128;

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		d = 8'h00;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			d = c - CHAR_0;
			return {1'b1, d[3:0]};
		end else if (c >= CHAR_LA && c <= CHAR_LF) begin
			d = c - CHAR_LA + 8'd10;
			return {1'b1, d[3:0]};
		end else if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
			return {1'b1, d[3:0]};
		end
		return 5'b0_0000;
	endfunction

	// Everything the assembly stage needs from one complete text.
	typedef struct packed {
		logic [GROUP_SLOTS-1:0][GROUP_W-1:0] head;
		logic [GROUP_SLOTS-1:0][GROUP_W-1:0] tail;
		logic [GROUP_CNT_W-1:0]              head_cnt;
		logic [GROUP_CNT_W-1:0]              tail_cnt;
		logic [7:0]                          prefix;
		logic                                mode;
	} snap_t;

endpackage

/* sv/ipv6_text_prefix_parser.sv */
// ----------------------------------------------------------------------------
// IPv6 text address parser with optional prefix length
// Top level: configuration register, character unit and assembly stage.
// ----------------------------------------------------------------------------
// Usage:
// The text channel takes one ASCII character per beat on text_char, with
// last_char set on the final character of an address. The result channel
// gives one beat per text: addr_high and addr_low hold the 128-bit address,
// group 0 in the top bits of addr_high, and prefix_length holds the parsed
// length. With prefix_mode set, "/length" is parsed and host bits beyond the
// length are cleared; prefix_mode is written through cfg_wr_en/cfg_wr_data,
// and the user must do so only while the block is idle: the block does not
// enforce it. Throughput is one character per cycle, with no gap between
// texts, unless a stalled receiver holds a finished text back.
// A result is registered in the character unit, then in the assembly stage.
// Reset clears the mode, the text state and all valid flags.
// When the receiver stalls, the result is held in the output register and
// one more finished text waits in the snapshot register; characters that do
// not end a text keep flowing until a second text ends behind them.
// ----------------------------------------------------------------------------
module ipv6_text_prefix_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_char,
	input  logic        last_char,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low,
	output logic [7:0]  prefix_length
);
	import ipv6p_pkg::*;

	logic  prefix_mode_q;
	logic  snap_valid;
	logic  snap_ready;
	snap_t snap;

	// Mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			prefix_mode_q <= cfg_wr_data;
		end
	end

	ipv6p_char_unit u_char_unit (
		.clk         (clk),
		.arst_n      (arst_n),
		.prefix_mode (prefix_mode_q),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_char   (text_char),
		.last_char   (last_char),
		.snap_valid  (snap_valid),
		.snap_ready  (snap_ready),
		.snap        (snap)
	);

	ipv6p_assemble u_assemble (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready),
		.snap          (snap),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.prefix_length (prefix_length)
	);

endmodule

/* sv/ipv6p_char_unit.sv */
// ----------------------------------------------------------------------------
// IPv6 text parser character unit
// Registers each character beat, updates the group, colon and prefix state
// from that register and on the last character snapshots the text.
// ----------------------------------------------------------------------------
module ipv6p_char_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prefix_mode,
	input  logic            text_valid,
	output logic            text_ready,
	input  logic [7:0]      text_char,
	input  logic            last_char,
	output logic            snap_valid,
	input  logic            snap_ready,
	output ipv6p_pkg::snap_t snap
);
	import ipv6p_pkg::*;

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Text state.
	logic [GROUP_W-1:0]     head_q [GROUP_SLOTS];
	logic [GROUP_W-1:0]     tail_q [GROUP_SLOTS];
	logic [GROUP_CNT_W-1:0] head_cnt_q;
	logic [GROUP_CNT_W-1:0] tail_cnt_q;
	logic [GROUP_W-1:0]     group_q;
	logic [1:0]             gflags_q;
	logic [1:0]             cflags_q;
	logic                   in_prefix_q;
	logic [7:0]             prefix_q;

	// Snapshot register.
	snap_t snap_s2;
	logic  snap_valid_s2;

	logic s2_free;
	logic s1_take;

	// Next-state values.
	logic [GROUP_W-1:0]     gv_n;
	logic [1:0]             gf_n;
	logic [1:0]             cf_n;
	logic                   inp_n;
	logic [7:0]             pv_n;
	logic [GROUP_CNT_W-1:0] hc_n;
	logic [GROUP_CNT_W-1:0] tc_n;
	logic                   do_close;
	logic [GROUP_W-1:0]     cap_v;
	logic [1:0]             cap_f;
	logic                   wr_head;
	logic                   wr_tail;
	logic [GROUP_IDX_W-1:0] wr_idx;
	logic [GROUP_W-1:0]     wr_val;
	logic [4:0]             hd;
	logic [10:0]            pfx_sum;
	snap_t                  snap_n;

	assign s2_free    = !snap_valid_s2 || snap_ready;
	assign s1_take    = valid_s1 && (!last_s1 || s2_free);
	assign text_ready = !valid_s1 || s1_take;
	assign snap_valid = snap_valid_s2;
	assign snap       = snap_s2;

	// Input register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && text_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			char_s1 <= text_char;
			last_s1 <= last_char;
		end
	end

	// Character step: digits, colons, slash and prefix digits.
	always_comb begin
		gv_n     = group_q;
		gf_n     = gflags_q;
		cf_n     = cflags_q;
		inp_n    = in_prefix_q;
		pv_n     = prefix_q;
		do_close = 1'b0;
		cap_v    = group_q;
		cap_f    = gflags_q;
		hd       = hex_digit(char_s1);
		pfx_sum  = {3'b000, prefix_q} * 11'd10 + {7'b0, hd[3:0]};

		if (in_prefix_q) begin
			if (!gflags_q[1]) begin
				if (char_s1 >= CHAR_0 && char_s1 <= CHAR_9) begin
					pv_n = (pfx_sum > {3'b000, PREFIX_MAX}) ? PREFIX_MAX : pfx_sum[7:0];
				end else begin
					gf_n = 2'b10;
				end
			end
		end else if (char_s1 == CHAR_COLON) begin
			do_close = 1'b1;
			gv_n     = '0;
			gf_n     = 2'b00;
			if (cflags_q[0] && !cflags_q[1]) begin
				cf_n[1] = 1'b1;
			end
			cf_n[0] = 1'b1;
		end else begin
			cf_n[0] = 1'b0;
			if (char_s1 == CHAR_SLASH && prefix_mode) begin
				do_close = 1'b1;
				gv_n     = '0;
				gf_n     = 2'b00;
				inp_n    = 1'b1;
			end else if (hd[4] && !gflags_q[1]) begin
				gv_n    = {group_q[GROUP_W-5:0], hd[3:0]};
				gf_n[0] = 1'b1;
			end else if (!hd[4]) begin
				gf_n[1] = 1'b1;
			end
		end

		// The last character closes the open group outside the prefix.
		if (last_s1 && !inp_n && !do_close) begin
			do_close = 1'b1;
			cap_v    = gv_n;
			cap_f    = gf_n;
		end
	end

	// Group store: at most one group is written per character.
	always_comb begin
		wr_head = 1'b0;
		wr_tail = 1'b0;
		wr_idx  = '0;
		wr_val  = cap_f[0] ? cap_v : '0;
		hc_n    = head_cnt_q;
		tc_n    = tail_cnt_q;
		if (do_close && cap_f != 2'b00 &&
				({1'b0, head_cnt_q} + {1'b0, tail_cnt_q}) < (GROUP_CNT_W+1)'(GROUP_SLOTS)) begin
			if (cflags_q[1]) begin
				wr_tail = 1'b1;
				wr_idx  = tail_cnt_q[GROUP_IDX_W-1:0];
				tc_n    = tail_cnt_q + 1'b1;
			end else begin
				wr_head = 1'b1;
				wr_idx  = head_cnt_q[GROUP_IDX_W-1:0];
				hc_n    = head_cnt_q + 1'b1;
			end
		end
	end

	// Snapshot of the finished text, including this cycle's store.
	always_comb begin
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			snap_n.head[i] = (wr_head && wr_idx == GROUP_IDX_W'(i)) ? wr_val : head_q[i];
			snap_n.tail[i] = (wr_tail && wr_idx == GROUP_IDX_W'(i)) ? wr_val : tail_q[i];
		end
		snap_n.head_cnt = hc_n;
		snap_n.tail_cnt = tc_n;
		snap_n.prefix   = pv_n;
		snap_n.mode     = prefix_mode;
	end

	// Control state; a last character starts a fresh text.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_cnt_q  <= '0;
			tail_cnt_q  <= '0;
			group_q     <= '0;
			gflags_q    <= '0;
			cflags_q    <= '0;
			in_prefix_q <= 1'b0;
			prefix_q    <= '0;
		end else if (s1_take) begin
			if (last_s1) begin
				head_cnt_q  <= '0;
				tail_cnt_q  <= '0;
				group_q     <= '0;
				gflags_q    <= '0;
				cflags_q    <= '0;
				in_prefix_q <= 1'b0;
				prefix_q    <= '0;
			end else begin
				head_cnt_q  <= hc_n;
				tail_cnt_q  <= tc_n;
				group_q     <= gv_n;
				gflags_q    <= gf_n;
				cflags_q    <= cf_n;
				in_prefix_q <= inp_n;
				prefix_q    <= pv_n;
			end
		end
	end

	// Group storage; only entries below the counts are ever read.
	always_ff @(posedge clk) begin
		if (s1_take && wr_head) begin
			head_q[wr_idx] <= wr_val;
		end
		if (s1_take && wr_tail) begin
			tail_q[wr_idx] <= wr_val;
		end
	end

	// Snapshot register handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s2 <= 1'b0;
		end else if (s1_take && last_s1) begin
			snap_valid_s2 <= 1'b1;
		end else if (snap_ready) begin
			snap_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && last_s1) begin
			snap_s2 <= snap_n;
		end
	end

	// The two stores never hold more groups than there are slots.
	a_group_count: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, head_cnt_q} + {1'b0, tail_cnt_q}) <= (GROUP_CNT_W+1)'(GROUP_SLOTS))
		else $error("group counts exceed the slot count");

	// Prefix digits only build up after a slash.
	a_prefix_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_prefix_q |-> prefix_q == '0)
		else $error("prefix value set outside the prefix");

	// A last character leaves a clean state behind.
	a_text_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s1_take && last_s1 |=> head_cnt_q == '0 && tail_cnt_q == '0 && !in_prefix_q)
		else $error("text state not cleared after the last character");

endmodule

/* sv/ipv6p_assemble.sv */
// ----------------------------------------------------------------------------
// IPv6 text parser assembly stage
// Places head groups, zero fill and tail groups into the 128-bit address,
// clears host bits in prefix mode and holds the result in the output register.
// ----------------------------------------------------------------------------
module ipv6p_assemble (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             snap_valid,
	output logic             snap_ready,
	input  ipv6p_pkg::snap_t snap,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [63:0]      addr_high,
	output logic [63:0]      addr_low,
	output logic [7:0]       prefix_length
);
	import ipv6p_pkg::*;

	logic                   result_valid_q;
	logic [63:0]            addr_high_q;
	logic [63:0]            addr_low_q;
	logic [7:0]             prefix_length_q;

	logic [GROUP_W-1:0]     grp [GROUP_SLOTS];
	logic [GROUP_CNT_W-1:0] tail_start;
	logic [GROUP_CNT_W-1:0] tail_off;
	logic [63:0]            hi;
	logic [63:0]            lo;
	logic [63:0]            mask_hi;
	logic [63:0]            mask_lo;
	logic [7:0]             plen;
	logic [7:0]             plen_lo;
	logic                   out_free;

	assign out_free      = !result_valid_q || result_ready;
	assign snap_ready    = out_free;
	assign result_valid  = result_valid_q;
	assign addr_high     = addr_high_q;
	assign addr_low      = addr_low_q;
	assign prefix_length = prefix_length_q;

	// Group placement: head from the top, tail against the bottom.
	always_comb begin
		tail_start = GROUP_CNT_W'(GROUP_SLOTS) - snap.tail_cnt;
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			tail_off = GROUP_CNT_W'(i) - tail_start;
			if (GROUP_CNT_W'(i) < snap.head_cnt) begin
				grp[i] = snap.head[i];
			end else if (GROUP_CNT_W'(i) >= tail_start) begin
				grp[i] = snap.tail[tail_off[GROUP_IDX_W-1:0]];
			end else begin
				grp[i] = '0;
			end
		end
		hi = {grp[0], grp[1], grp[2], grp[3]};
		lo = {grp[4], grp[5], grp[6], grp[7]};
	end

	// Host-bit masks from the prefix length.
	always_comb begin
		plen    = snap.mode ? snap.prefix : 8'd0;
		plen_lo = plen - 8'd64;
		if (plen >= 8'd64) begin
			mask_hi = '1;
		end else begin
			mask_hi = ~({64{1'b1}} >> plen[5:0]);
		end
		if (plen <= 8'd64) begin
			mask_lo = '0;
		end else if (plen >= PREFIX_MAX) begin
			mask_lo = '1;
		end else begin
			mask_lo = ~({64{1'b1}} >> plen_lo[5:0]);
		end
		if (!snap.mode) begin
			mask_hi = '1;
			mask_lo = '1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && out_free) begin
			addr_high_q     <= hi & mask_hi;
			addr_low_q      <= lo & mask_lo;
			prefix_length_q <= plen;
		end
	end

	// A delivered prefix length never exceeds the address width.
	a_prefix_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> prefix_length_q <= PREFIX_MAX)
		else $error("prefix length out of range");

endmodule

/* tb/ipv6_text_prefix_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv6 text prefix parser testbench
// Streams address texts into the parser one character per beat. It predicts
// each 128-bit address and prefix length with a local parser model and
// compares every result beat field by field. Directed texts come first, then
// random well-formed, broken and noise texts in both modes, with random gaps
// on the sender, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ipv6_text_prefix_parser_test;
	import ipv6p_pkg::*;

	localparam logic MODE_ADDR_ONLY = 1'b0;
	localparam logic MODE_PREFIX    = 1'b1;

	localparam int RX_ALWAYS  = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	typedef logic [7:0] chars_t[$];

	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  plen;
	} addr_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_ready;
	logic [7:0]  text_char = 8'h00;
	logic        last_char = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [7:0]  prefix_length;

	// Local copy of the parser state and mode.
	logic        prefix_mode_q = MODE_ADDR_ONLY;
	logic [15:0] head_grp[GROUP_SLOTS];
	logic [15:0] tail_grp[GROUP_SLOTS];
	logic [3:0]  head_cnt;
	logic [3:0]  tail_cnt;
	logic [15:0] grp_val;
	logic [1:0]  grp_flags;
	logic [1:0]  colon_flags;
	logic        in_pfx;
	logic [7:0]  pfx_val;

	addr_result_t expected_addrs[$];
	addr_result_t want;

	int fail_count = 0;
	int lost_results = 0;
	int results_checked = 0;
	int chars_sent = 0;
	int texts_done = 0;
	int prefix_texts = 0;
	int mode_writes = 0;

	// Sender and receiver idling controls.
	bit sender_gaps = 1'b1;
	int burst_left = 0;
	int rx_style = RX_PATTERN;
	int hold_len = 0;
	int hold_serial = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic [15:0] stall_pat = 16'hffff;
	int pat_step = 0;

	ipv6_text_prefix_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text_char    (text_char),
		.last_char    (last_char),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.addr_high    (addr_high),
		.addr_low     (addr_low),
		.prefix_length(prefix_length)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Address predictor
	// ------------------------------------------------------------------

	// Forget the current text after a result or at reset.
	function automatic void clear_text();
		for (int i = 0; i < GROUP_SLOTS; i++) begin
			head_grp[i] = '0;
			tail_grp[i] = '0;
		end
		head_cnt = '0;
		tail_cnt = '0;
		grp_val = '0;
		grp_flags = '0;
		colon_flags = '0;
		in_pfx = 1'b0;
		pfx_val = '0;
	endfunction

	// Store the open group before or after the gap, dropping extras past eight.
	function automatic void close_group();
		logic [15:0] v;
		if (grp_flags != 2'b00) begin
			v = grp_flags[0] ? grp_val : 16'h0000;
			if (head_cnt + tail_cnt < GROUP_SLOTS) begin
				if (colon_flags[1]) begin
					tail_grp[tail_cnt[2:0]] = v;
					tail_cnt = tail_cnt + 4'd1;
				end else begin
					head_grp[head_cnt[2:0]] = v;
					head_cnt = head_cnt + 4'd1;
				end
			end
		end
		grp_val = '0;
		grp_flags = '0;
	endfunction

	// Advance the parser state by one character.
	function automatic void parse_char(input logic [7:0] c);
		logic       is_hex;
		logic       is_dec;
		logic [7:0] nib;
		int         acc;
		is_dec = (c >= CHAR_0 && c <= CHAR_9);
		is_hex = 1'b1;
		if (is_dec)
			nib = c - CHAR_0;
		else if (c >= CHAR_LA && c <= CHAR_LF)
			nib = c - CHAR_LA + 8'd10;
		else if (c >= CHAR_UA && c <= CHAR_UF)
			nib = c - CHAR_UA + 8'd10;
		else begin
			nib = 8'h00;
			is_hex = 1'b0;
		end

		// After the slash only decimal digits count, until the first other character.
		if (in_pfx) begin
			if (!grp_flags[1]) begin
				if (is_dec) begin
					acc = int'(pfx_val) * 10 + int'(c - CHAR_0);
					pfx_val = (acc > int'(PREFIX_MAX)) ? PREFIX_MAX : acc[7:0];
				end else begin
					grp_flags = 2'b10;
				end
			end
			return;
		end

		// Only the first double colon opens the gap.
		if (c == CHAR_COLON) begin
			close_group();
			if (colon_flags[0] && !colon_flags[1])
				colon_flags[1] = 1'b1;
			colon_flags[0] = 1'b1;
			return;
		end
		colon_flags[0] = 1'b0;

		if (c == CHAR_SLASH && prefix_mode_q == MODE_PREFIX) begin
			close_group();
			in_pfx = 1'b1;
			return;
		end

		if (is_hex && !grp_flags[1]) begin
			grp_val = {grp_val[11:0], nib[3:0]};
			grp_flags[0] = 1'b1;
		end else if (!is_hex) begin
			grp_flags[1] = 1'b1;
		end
	endfunction

	// Take one accepted character; on the last one queue the expected address.
	function automatic void predict_char(input logic [7:0] c, input logic is_last);
		logic [15:0]  g[GROUP_SLOTS];
		logic [63:0]  mask_hi;
		logic [63:0]  mask_lo;
		int           p;
		addr_result_t r;
		parse_char(c);
		if (!is_last)
			return;
		if (!in_pfx)
			close_group();

		// Head groups from the left, tail groups against the right end.
		for (int i = 0; i < GROUP_SLOTS; i++)
			g[i] = 16'h0000;
		for (int i = 0; i < head_cnt; i++)
			g[i] = head_grp[i];
		for (int i = 0; i < tail_cnt; i++)
			g[(GROUP_SLOTS - tail_cnt + i) % GROUP_SLOTS] = tail_grp[i];
		r.addr_hi = {g[0], g[1], g[2], g[3]};
		r.addr_lo = {g[4], g[5], g[6], g[7]};

		// Clear the host bits beyond the prefix length.
		p = 0;
		if (prefix_mode_q == MODE_PREFIX) begin
			p = pfx_val;
			if (p == 0)
				mask_hi = 64'h0;
			else if (p < 64)
				mask_hi = ~64'h0 << (64 - p);
			else
				mask_hi = ~64'h0;
			if (p <= 64)
				mask_lo = 64'h0;
			else if (p < 128)
				mask_lo = ~64'h0 << (128 - p);
			else
				mask_lo = ~64'h0;
			r.addr_hi &= mask_hi;
			r.addr_lo &= mask_lo;
			prefix_texts++;
		end
		r.plen = p[7:0];
		expected_addrs.push_back(r);
		texts_done++;
		clear_text();
	endfunction

	// ------------------------------------------------------------------
	// Result checking and receiver stalls
	// ------------------------------------------------------------------

	// Compare each result beat with the oldest pending address.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_addrs.size() == 0) begin
				$error("result beat with no text pending: %h %h %0d",
					addr_high, addr_low, prefix_length);
				fail_count++;
			end else begin
				want = expected_addrs.pop_front();
				results_checked++;
				if (addr_high !== want.addr_hi) begin
					$error("addr_high: expected %h, got %h", want.addr_hi, addr_high);
					fail_count++;
				end
				if (addr_low !== want.addr_lo) begin
					$error("addr_low: expected %h, got %h", want.addr_lo, addr_low);
					fail_count++;
				end
				if (prefix_length !== want.plen) begin
					$error("prefix_length: expected %0d, got %0d", want.plen, prefix_length);
					fail_count++;
				end
			end
		end
	end

	// The receiver follows its style, except during a requested hold-off.
	always @(posedge clk) begin
		if (hold_serial != hold_seen) begin
			hold_seen = hold_serial;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_RANDOM: result_ready <= ($urandom_range(0, 9) >= 3);
				RX_PATTERN: begin
					if (pat_step == 0)
						stall_pat = 16'($urandom()) | 16'h0101;
					result_ready <= stall_pat[pat_step];
					pat_step = (pat_step + 1) % 16;
				end
				default: result_ready <= 1'b1;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic void add_str(ref chars_t q, input string s);
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_hex_char();
		logic [7:0] v;
		v = 8'($urandom_range(0, 15));
		if (v < 8'd10)
			return CHAR_0 + v;
		return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + v - 8'd10;
	endfunction

	function automatic void add_group(ref chars_t q, input int n_digits);
		repeat (n_digits) q.push_back(rand_hex_char());
	endfunction

	// One random text: mostly well-formed, some broken by edits, some pure noise.
	function automatic chars_t build_text(input bit with_prefix);
		chars_t q;
		string  noise_set;
		int     kind;
		int     h_n;
		int     t_n;
		int     total;
		int     pos;
		bit     gap;
		noise_set = ":/0123456789abcdefABCDEFxz.";
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 10)) begin
				if ($urandom_range(0, 1))
					q.push_back(noise_set[$urandom_range(0, noise_set.len() - 1)]);
				else
					q.push_back(8'($urandom_range(0, 255)));
			end
			return q;
		end

		gap = 1'($urandom_range(0, 1));
		if (gap) begin
			total = $urandom_range(0, 7);
			h_n = $urandom_range(0, total);
			t_n = total - h_n;
		end else begin
			h_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 8;
			t_n = 0;
		end
		for (int i = 0; i < h_n; i++) begin
			if (i > 0)
				q.push_back(CHAR_COLON);
			add_group(q, $urandom_range(1, 4));
		end
		if (gap)
			add_str(q, "::");
		for (int i = 0; i < t_n; i++) begin
			if (i > 0)
				q.push_back(CHAR_COLON);
			add_group(q, $urandom_range(1, 4));
		end

		if (with_prefix) begin
			q.push_back(CHAR_SLASH);
			case ($urandom_range(0, 9))
				0: add_str(q, "0");
				1: add_str(q, "128");
				2: add_str(q, $sformatf("%0d", $urandom_range(129, 999)));
				default: add_str(q, $sformatf("%0d", $urandom_range(0, 128)));
			endcase
		end

		// Broken texts: stray bytes, extra colons, long groups, surplus groups.
		if (kind >= 75) begin
			repeat ($urandom_range(1, 3)) begin
				pos = $urandom_range(0, q.size() - 1);
				case ($urandom_range(0, 3))
					0: q[pos] = 8'($urandom_range(0, 255));
					1: q.insert(pos, CHAR_COLON);
					2: repeat ($urandom_range(1, 4)) q.insert(pos, rand_hex_char());
					default: repeat ($urandom_range(1, 4)) begin
						q.insert(pos, CHAR_COLON);
						q.insert(pos, rand_hex_char());
					end
				endcase
			end
		end
		return q;
	endfunction

	// Offer one character beat, with a random gap at the end of each burst.
	task automatic send_char(input logic [7:0] c, input logic is_last);
		if (sender_gaps) begin
			if (burst_left == 0) begin
				text_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
		end
		text_valid <= 1'b1;
		text_char <= c;
		last_char <= is_last;
		@(posedge clk);
		while (!text_ready) @(posedge clk);
		predict_char(c, is_last);
		chars_sent++;
	endtask

	task automatic send_text(input chars_t q, input bit ends_text);
		for (int i = 0; i < q.size(); i++)
			send_char(q[i], ends_text && (i == q.size() - 1));
	endtask

	// Stop sending and wait until every pending address has come out.
	task automatic wait_results_done();
		int guard;
		guard = 0;
		text_valid <= 1'b0;
		while (expected_addrs.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_addrs.size() != 0) begin
			$error("%0d expected results never arrived", expected_addrs.size());
			lost_results += expected_addrs.size();
			expected_addrs.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_prefix_mode(input logic mode);
		wait_results_done();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		prefix_mode_q = mode;
		mode_writes++;
	endtask

	// Random texts until the character budget is spent.
	task automatic run_random(input int char_budget, input bit mix_modes);
		chars_t q;
		int     stop_at;
		bit     with_pfx;
		stop_at = chars_sent + char_budget;
		while (chars_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0) begin
				sender_gaps = 1'($urandom_range(0, 1));
				rx_style = int'($urandom_range(RX_ALWAYS, RX_PATTERN));
			end
			if (mix_modes && $urandom_range(0, 4) == 0)
				set_prefix_mode(!prefix_mode_q);
			with_pfx = ($urandom_range(0, 5) == 0) ? !prefix_mode_q : prefix_mode_q;
			q = build_text(with_pfx);
			send_text(q, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Long group, junk after digits, NUL, a triple colon, a slash as junk,
	// too many groups, a second double colon and a short text without gap.
	task automatic test_directed_address();
		chars_t q;
		set_prefix_mode(MODE_ADDR_ONLY);
		add_str(q, "F1234:8");
		q.push_back(8'h00);
		add_str(q, "9:::/");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "1:2:3:4:5:6:7:8:9");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "a::b::c");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "1:2");
		send_text(q, 1'b1);
	endtask

	// Saturating prefix stopped by 0xff, a missing prefix, a second slash.
	task automatic test_directed_prefix();
		chars_t q;
		set_prefix_mode(MODE_PREFIX);
		add_str(q, "::1/999");
		q.push_back(8'hff);
		add_str(q, "5");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "ab:cd");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "1::/1/9");
		send_text(q, 1'b1);
	endtask

	// The slash follows the mode at its arrival, masking the mode at the end.
	task automatic test_mode_change_mid_text();
		chars_t q;
		set_prefix_mode(MODE_ADDR_ONLY);
		add_str(q, "ffff:");
		send_text(q, 1'b0);
		set_prefix_mode(MODE_PREFIX);
		q.delete();
		add_str(q, "/64");
		send_text(q, 1'b1);
		q.delete();
		add_str(q, "12");
		send_text(q, 1'b0);
		set_prefix_mode(MODE_ADDR_ONLY);
		q.delete();
		add_str(q, "/3");
		send_text(q, 1'b1);
	endtask

	task automatic test_random_address();
		set_prefix_mode(MODE_ADDR_ONLY);
		run_random(250, 1'b0);
	endtask

	task automatic test_random_prefix();
		set_prefix_mode(MODE_PREFIX);
		run_random(400, 1'b0);
	endtask

	// Receiver holds off while texts keep coming, so the input must stall.
	task automatic test_back_pressure();
		sender_gaps = 1'b0;
		hold_len = 250;
		hold_serial++;
		repeat (8) send_text(build_text(prefix_mode_q), 1'b1);
		wait_results_done();
		sender_gaps = 1'b1;
		rx_style = RX_PATTERN;
		repeat (4) send_text(build_text(prefix_mode_q), 1'b1);
	endtask

	task automatic test_random_mode_mix();
		run_random(400, 1'b1);
	endtask

	initial begin
		clear_text();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_address();
		test_directed_prefix();
		test_mode_change_mid_text();
		test_random_address();
		test_random_prefix();
		test_back_pressure();
		test_random_mode_mix();

		wait_results_done();
		$display("Parsed %0d texts from %0d characters; %0d result beats checked.",
			texts_done, chars_sent, results_checked);
		$display("%0d texts in prefix mode, %0d mode register writes, one long hold-off.",
			prefix_texts, mode_writes);
		if (fail_count == 0 && lost_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
